// ===== design/pair_code_dictionary_macros.svh =====
// Assertion macros shared by the dictionary RTL.
// Each one samples on aclk. The first form is disabled while aresetn is low.
`ifndef PAIR_CODE_DICTIONARY_MACROS_SVH
`define PAIR_CODE_DICTIONARY_MACROS_SVH

`ifndef SYNTHESIS

`define PCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define PCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define PCD_ASSERT(lbl, prop, msg)

`define PCD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/pcd_pkg.sv =====
package pcd_pkg;

    // Dictionary geometry
    localparam int TERRAIN_KINDS    = 128;
    localparam int ELEVATION_LEVELS = 16;
    localparam int CODE_SLOTS       = 255;

    // Field widths
    localparam int TER_W  = 7;
    localparam int ELEV_W = 4;
    localparam int CODE_W = 8;
    localparam int STAT_W = 2;
    localparam int PAIR_W = TER_W + ELEV_W;

    localparam int SLOTS  = TERRAIN_KINDS * ELEVATION_LEVELS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int REV_W  = $clog2(CODE_SLOTS);

    localparam logic [CODE_W-1:0] CODE_LIMIT = CODE_W'(CODE_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);

    // Stream data widths, rounded up to whole bytes
    localparam int S_DATA_W = ((TER_W + ELEV_W + CODE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CODE_W + TER_W + ELEV_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_FOUND      = 2'd0,
        STAT_NEW        = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_UNASSIGNED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

endpackage

// ===== design/pair_code_dictionary.sv =====
// Channel   | Direction | tdata (low bit up)                    | tuser
// ----------+-----------+---------------------------------------+---------------
// s_ (item) | in        | terrain, elevation, code_in           | command
// m_ (res)  | out       | code_out, terrain_out, elevation_out  | status
//
// Each item passes through an accept cycle that issues the reads of the
// forward table (pair -> code) and the reverse table (code -> pair), and a
// lookup cycle that resolves the result and writes back a new assignment.
// After reset a clearing pass zeroes the 2048-entry forward table, one entry
// per cycle; s_tready stays low during the pass.
// A result waiting in the output register stalls the lookup cycle only when
// the next result is ready and m_tready is low.
module pair_code_dictionary (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [6:0] terrain, [10:7] elevation, [18:11] code_in, rest zero
    input  logic [pcd_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] command
    input  logic [0:0]                    s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] code_out, [14:8] terrain_out, [18:15] elevation_out, rest zero
    output logic [pcd_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [pcd_pkg::STAT_W-1:0]    m_tuser
);

`include "pair_code_dictionary_macros.svh"

    localparam int TW = pcd_pkg::TER_W;
    localparam int EW = pcd_pkg::ELEV_W;
    localparam int CW = pcd_pkg::CODE_W;

    // Unpack the input transfer
    logic [TW-1:0] s_terrain;
    logic [EW-1:0] s_elevation;
    logic [CW-1:0] s_code_in;

    assign s_terrain   = s_tdata[TW-1:0];
    assign s_elevation = s_tdata[TW+EW-1:TW];
    assign s_code_in   = s_tdata[TW+EW+CW-1:TW+EW];

    // Control state
    pcd_pkg::state_t                state_reg, state_next;
    logic [pcd_pkg::SLOT_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [CW-1:0]                  codes_used_reg, codes_used_next;
    logic                           m_valid_reg, m_valid_next;

    // Latched item (payload, no reset)
    pcd_pkg::cmd_t                  cmd_reg;
    logic [TW-1:0]                  ter_reg;
    logic [EW-1:0]                  elev_reg;
    logic [CW-1:0]                  code_reg;
    logic [pcd_pkg::SLOT_W-1:0]     slot_reg;

    // Output register (payload)
    logic [pcd_pkg::M_DATA_W-1:0]   m_data_reg;
    pcd_pkg::status_t               m_stat_reg;

    // Memories
    logic [CW-1:0]                  fwd_mem [pcd_pkg::SLOTS];
    logic [pcd_pkg::PAIR_W-1:0]     rev_mem [pcd_pkg::CODE_SLOTS];
    logic [CW-1:0]                  fwd_rd_reg;
    logic [pcd_pkg::PAIR_W-1:0]     rev_rd_reg;

    logic                           accept;
    logic                           out_free;
    logic                           load;
    logic [TW-1:0]                  ter_sat;
    logic [EW-1:0]                  elev_sat;
    logic [pcd_pkg::SLOT_W-1:0]     slot;

    logic                           fwd_we;
    logic [pcd_pkg::SLOT_W-1:0]     fwd_waddr;
    logic [CW-1:0]                  fwd_wdata;
    logic                           rev_we;
    logic                           rev_re;
    logic                           new_assign;

    logic [CW-1:0]                  res_code;
    logic [TW-1:0]                  res_ter;
    logic [EW-1:0]                  res_elev;
    pcd_pkg::status_t               res_stat;

    assign s_tready = (state_reg == pcd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load     = (state_reg == pcd_pkg::ST_LOOKUP) && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

    // Saturate the pair into range and form the forward-table slot
    always_comb begin
        ter_sat  = s_terrain;
        elev_sat = s_elevation;
        if (int'(s_terrain) >= pcd_pkg::TERRAIN_KINDS) begin
            ter_sat = TW'(pcd_pkg::TERRAIN_KINDS - 1);
        end
        if (int'(s_elevation) >= pcd_pkg::ELEVATION_LEVELS) begin
            elev_sat = EW'(pcd_pkg::ELEVATION_LEVELS - 1);
        end
        slot = pcd_pkg::SLOT_W'(int'(ter_sat) * pcd_pkg::ELEVATION_LEVELS + int'(elev_sat));
    end

    // Reverse table holds only CODE_SLOTS entries; skip reads past the end
    assign rev_re = accept && (s_code_in < pcd_pkg::CODE_LIMIT);

    // Resolve the result from the registered table reads
    always_comb begin
        res_code   = '0;
        res_ter    = '0;
        res_elev   = '0;
        res_stat   = pcd_pkg::STAT_FOUND;
        new_assign = 1'b0;
        if (cmd_reg == pcd_pkg::CMD_DECODE) begin
            res_code = code_reg;
            if ((code_reg >= codes_used_reg) || (code_reg >= pcd_pkg::CODE_LIMIT)) begin
                res_stat = pcd_pkg::STAT_UNASSIGNED;
            end else begin
                res_ter  = rev_rd_reg[pcd_pkg::PAIR_W-1:EW];
                res_elev = rev_rd_reg[EW-1:0];
            end
        end else if (fwd_rd_reg != '0) begin
            // Known pair: stored value is code plus one
            res_code = fwd_rd_reg - CW'(1);
            res_ter  = ter_reg;
            res_elev = elev_reg;
        end else if (codes_used_reg >= pcd_pkg::CODE_LIMIT) begin
            res_stat = pcd_pkg::STAT_FULL;
        end else begin
            res_code   = codes_used_reg;
            res_ter    = ter_reg;
            res_elev   = elev_reg;
            res_stat   = pcd_pkg::STAT_NEW;
            new_assign = 1'b1;
        end
    end

    // Forward-table write port: zero during the clearing pass, else new code plus one on a new assignment
    always_comb begin
        fwd_we    = 1'b0;
        fwd_waddr = slot_reg;
        fwd_wdata = codes_used_reg + CW'(1);
        rev_we    = 1'b0;
        if (state_reg == pcd_pkg::ST_CLEAR) begin
            fwd_we    = 1'b1;
            fwd_waddr = clr_idx_reg;
            fwd_wdata = '0;
        end else if (load && new_assign) begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
        end
    end

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        codes_used_next = codes_used_reg;
        m_valid_next    = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pcd_pkg::ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + pcd_pkg::SLOT_W'(1);
                if (clr_idx_reg == pcd_pkg::SLOT_LAST) begin
                    state_next = pcd_pkg::ST_IDLE;
                end
            end
            pcd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pcd_pkg::ST_LOOKUP;
                end
            end
            pcd_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = pcd_pkg::ST_IDLE;
                    if (new_assign) begin
                        codes_used_next = codes_used_reg + CW'(1);
                    end
                end
            end
            default: begin
                state_next = pcd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pcd_pkg::ST_CLEAR;
            clr_idx_reg    <= '0;
            codes_used_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            codes_used_reg <= codes_used_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the accepted item for the lookup cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= pcd_pkg::cmd_t'(s_tuser[0]);
            ter_reg  <= ter_sat;
            elev_reg <= elev_sat;
            code_reg <= s_code_in;
            slot_reg <= slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= pcd_pkg::M_DATA_W'({res_elev, res_ter, res_code});
            m_stat_reg <= res_stat;
        end
    end

    // Forward table: pair slot -> code plus one, zero when unassigned
    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (accept) begin
            fwd_rd_reg <= fwd_mem[slot];
        end
    end

    // Reverse table: code -> pair, written once per assigned code
    always_ff @(posedge aclk) begin
        if (rev_we) begin
            rev_mem[codes_used_reg[pcd_pkg::REV_W-1:0]] <= {ter_reg, elev_reg};
        end
        if (rev_re) begin
            rev_rd_reg <= rev_mem[s_code_in[pcd_pkg::REV_W-1:0]];
        end
    end

    `PCD_ASSERT(a_codes_bound, codes_used_reg <= pcd_pkg::CODE_LIMIT, "code counter past limit")
    `PCD_ASSERT(a_count_step, load && new_assign |=> codes_used_reg == $past(codes_used_reg) + CW'(1), "code counter did not advance")
    `PCD_ASSERT(a_new_code, load && new_assign |=> m_tdata[CW-1:0] == $past(codes_used_reg) && m_tuser == pcd_pkg::STAT_NEW, "new code mismatch")
    `PCD_ASSERT(a_no_write_on_read, accept |-> !fwd_we && !rev_we, "table write overlaps a read")

endmodule

// ===== test/pair_code_dictionary_test.sv =====
module pair_code_dictionary_test;

    // Run length and pressure points
    localparam int RANDOM_ITEMS   = 500;
    localparam int CALM_TAIL      = 60;     // last transfers run with no idling
    localparam int HOLDOFF_AT     = 150;    // result count that starts the long hold-off
    localparam int HOLDOFF_CYCLES = 60;
    localparam int DRAIN_AT       = 200;    // random item that waits for an empty pipe
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 40000;

    // One command on the item channel
    typedef struct {
        pcd_pkg::cmd_t              cmd;
        logic [pcd_pkg::TER_W-1:0]  terrain;
        logic [pcd_pkg::ELEV_W-1:0] elevation;
        logic [pcd_pkg::CODE_W-1:0] code;
        bit                         drain_first;     // hold until every answer is back
    } dict_req_t;

    // One answer on the result channel
    typedef struct {
        logic [pcd_pkg::CODE_W-1:0] code;
        logic [pcd_pkg::TER_W-1:0]  terrain;
        logic [pcd_pkg::ELEV_W-1:0] elevation;
        pcd_pkg::status_t           status;
    } dict_resp_t;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pcd_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]                   s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pcd_pkg::M_DATA_W-1:0] m_tdata;
    logic [pcd_pkg::STAT_W-1:0]   m_tuser;

    pair_code_dictionary dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow dictionary: code plus one per pair slot, pair per code
    logic [pcd_pkg::CODE_W-1:0] slot_code [pcd_pkg::SLOTS];
    logic [pcd_pkg::PAIR_W-1:0] code_pair [pcd_pkg::CODE_SLOTS];
    int unsigned                codes_given;

    // Stimulus bookkeeping: which pairs have been issued so far
    bit                         gen_seen [pcd_pkg::SLOTS];
    logic [pcd_pkg::PAIR_W-1:0] gen_pairs [$];

    dict_req_t   requests_queued [$];
    dict_resp_t  answers_due [$];
    dict_req_t   offered;
    int unsigned items_total;
    int unsigned accepted;
    int unsigned results_seen;      // counted by the driver for the drain pause
    int unsigned results_taken;     // counted by the monitor
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          holdoff_done;
    int unsigned mismatches;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the answer to one accepted command and update the shadow tables.
    function automatic dict_resp_t intern_lookup(dict_req_t req);
        dict_resp_t  ans;
        int unsigned slot;
        ans.code      = '0;
        ans.terrain   = '0;
        ans.elevation = '0;
        ans.status    = pcd_pkg::STAT_FOUND;
        if (req.cmd == pcd_pkg::CMD_ENCODE) begin
            slot = req.terrain * pcd_pkg::ELEVATION_LEVELS + req.elevation;
            if (slot_code[slot] != '0) begin
                // known pair: echo it with its stored code
                ans.code      = slot_code[slot] - 1'b1;
                ans.terrain   = req.terrain;
                ans.elevation = req.elevation;
            end else if (codes_given >= pcd_pkg::CODE_SLOTS) begin
                // every code is taken: assign nothing, zero payload
                ans.status = pcd_pkg::STAT_FULL;
            end else begin
                code_pair[codes_given] = {req.elevation, req.terrain};
                ans.code               = pcd_pkg::CODE_W'(codes_given);
                codes_given++;
                slot_code[slot]        = pcd_pkg::CODE_W'(codes_given);
                ans.terrain            = req.terrain;
                ans.elevation          = req.elevation;
                ans.status             = pcd_pkg::STAT_NEW;
            end
        end else begin
            ans.code = req.code;
            if (req.code >= codes_given) begin
                ans.status = pcd_pkg::STAT_UNASSIGNED;
            end else begin
                {ans.elevation, ans.terrain} = code_pair[req.code];
            end
        end
        return ans;
    endfunction

    // Append one command, tracking the pairs that encode commands introduce.
    function automatic void queue_request(pcd_pkg::cmd_t cmd, int unsigned ter,
                                          int unsigned elev, int unsigned code,
                                          bit drain_first);
        dict_req_t   req;
        int unsigned slot;
        req.cmd         = cmd;
        req.terrain     = pcd_pkg::TER_W'(ter);
        req.elevation   = pcd_pkg::ELEV_W'(elev);
        req.code        = pcd_pkg::CODE_W'(code);
        req.drain_first = drain_first;
        if (cmd == pcd_pkg::CMD_ENCODE) begin
            slot = req.terrain * pcd_pkg::ELEVATION_LEVELS + req.elevation;
            if (!gen_seen[slot]) begin
                gen_seen[slot] = 1'b1;
                gen_pairs.push_back({req.elevation, req.terrain});
            end
        end
        requests_queued.push_back(req);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Stimulus, reset and the end of the run
    initial begin
        dict_req_t   req;
        int unsigned pick;
        int unsigned fresh_pct;
        int unsigned top_code;
        logic [pcd_pkg::PAIR_W-1:0] pair;

        for (int i = 0; i < pcd_pkg::SLOTS; i++) begin
            slot_code[i] = '0;
            gen_seen[i]  = 1'b0;
        end
        for (int i = 0; i < pcd_pkg::CODE_SLOTS; i++) code_pair[i] = '0;
        codes_given   = 0;
        accepted      = 0;
        results_seen  = 0;
        results_taken = 0;
        gap_left      = 0;
        stall_left    = 0;
        hold_left     = 0;
        holdoff_done  = 1'b0;
        mismatches    = 0;

        // Directed: empty-table decodes, field extremes, repeats, the code boundary
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 255, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 0, 0, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 127, 15, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 0, 0, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 127, 0, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 0, 15, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 1, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 3, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 4, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 127, 15, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 254, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 85, 10, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 42, 5, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 2, 1'b0);
        // a new pair, then a repeat of it that hits the code just assigned
        queue_request(pcd_pkg::CMD_ENCODE, 17, 9, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 17, 9, 0, 1'b0);
        queue_request(pcd_pkg::CMD_ENCODE, 33, 3, 0, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 7, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 0, 0, 8, 1'b0);
        queue_request(pcd_pkg::CMD_DECODE, 127, 15, 255, 1'b0);

        // Random: fill the table with mostly new pairs, then work the full table
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick      = $urandom_range(0, 99);
            fresh_pct = (gen_pairs.size() < pcd_pkg::CODE_SLOTS + 15) ? 70 : 25;
            top_code  = (gen_pairs.size() < 255) ? gen_pairs.size() : 255;
            if (pick < fresh_pct) begin
                queue_request(pcd_pkg::CMD_ENCODE, $urandom_range(0, 127),
                              $urandom_range(0, 15), $urandom_range(0, 255),
                              i == DRAIN_AT);
            end else if (pick < fresh_pct + 15) begin
                pair = gen_pairs[$urandom_range(0, gen_pairs.size() - 1)];
                queue_request(pcd_pkg::CMD_ENCODE, pair[pcd_pkg::TER_W-1:0],
                              pair[pcd_pkg::PAIR_W-1:pcd_pkg::TER_W],
                              $urandom_range(0, 255), i == DRAIN_AT);
            end else if (pick < fresh_pct + 22) begin
                // extremes of the pair fields
                queue_request(pcd_pkg::CMD_ENCODE, $urandom_range(0, 1) * 127,
                              $urandom_range(0, 1) * 15, $urandom_range(0, 255),
                              i == DRAIN_AT);
            end else if (pick < 92) begin
                queue_request(pcd_pkg::CMD_DECODE, $urandom_range(0, 127),
                              $urandom_range(0, 15), $urandom_range(0, top_code),
                              i == DRAIN_AT);
            end else begin
                queue_request(pcd_pkg::CMD_DECODE, $urandom_range(0, 127),
                              $urandom_range(0, 15), $urandom_range(0, 255),
                              i == DRAIN_AT);
            end
        end
        items_total = requests_queued.size();

        // Hold reset, then release it, once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait out every transfer, then let the pipe settle
        while (accepted < items_total || results_taken < items_total) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (answers_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, answers_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Give up once the run exceeds the cycle budget
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Driver: present queued commands, predict each transfer as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // count results here too, so the drain pause reads only this process
            if (m_tvalid && m_tready) results_seen++;
            if (s_tvalid && s_tready) begin
                answers_due.push_back(intern_lookup(offered));
                accepted++;
            end
            // hold the current command until it is taken
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (requests_queued.size() > 0 &&
                             !(requests_queued[0].drain_first && results_seen != accepted)) begin
                    offered = requests_queued.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pcd_pkg::S_DATA_W'({offered.code, offered.elevation,
                                                    offered.terrain});
                    s_tuser  <= offered.cmd;
                    // idle in short bursts, skipping a stretch of each hundred and the tail
                    if (requests_queued.size() > CALM_TAIL && (accepted % 100) < 70 &&
                        $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 3);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take results, compare with the oldest prediction, stall at random
    always @(posedge aclk) begin
        dict_resp_t got;
        dict_resp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.code      = m_tdata[pcd_pkg::CODE_W-1:0];
                got.terrain   = m_tdata[pcd_pkg::CODE_W +: pcd_pkg::TER_W];
                got.elevation = m_tdata[pcd_pkg::CODE_W+pcd_pkg::TER_W +: pcd_pkg::ELEV_W];
                got.status    = pcd_pkg::status_t'(m_tuser);
                results_taken++;
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual code %0d status %0d",
                             $time, got.code, got.status);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("code_out", want.code, got.code);
                    check_field("terrain_out", want.terrain, got.terrain);
                    check_field("elevation_out", want.elevation, got.elevation);
                    check_field("status", want.status, got.status);
                end
            end
            // start the long hold-off once, so the block fills and stalls its input
            if (!holdoff_done && results_taken == HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (results_taken + CALM_TAIL >= items_total ||
                         (results_taken % 100) >= 70) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

endmodule
